/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ATBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ATBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/atbs_pkg.sv */
package atbs_pkg;

  localparam int OP_W      = 3;
  localparam int MIN_W     = 11;
  localparam int PTYPE_W   = 2;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int PAT_W     = 32;
  localparam int NUM_CFG   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 24;
  localparam int OUT_W     = 16;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd2;
  localparam logic [OP_W-1:0] OP_NEW_DAY = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic shift_start;
    logic run;
    logic shift;
    logic add_commit;
    logic fire;
    logic reject;
    logic set_active;
    logic clear_fired;
    logic tick;
    logic dec;
    logic out_load;
  } atbs_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            idx_bad;
    logic            busy;
    logic            hit;
    logic            scan_end;
    logic            out_free;
  } atbs_stat_t;

endpackage

/* src/atbs_datapath.sv */
module atbs_datapath #(
  parameter int MAX_ALARMS   = 64,
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [atbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [atbs_pkg::PAT_W-1:0]          cfg_data,
  input  logic [atbs_pkg::IN_W-1:0]           s_tdata,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [atbs_pkg::OUT_W-1:0]          m_tdata,
  input  atbs_pkg::atbs_cmd_t                 cmd,
  output atbs_pkg::atbs_stat_t                stat
);

  localparam int CW   = $clog2(MAX_ALARMS + 1);
  localparam int AW   = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int BPW  = $clog2(PATTERN_BITS + 1);
  localparam int XW   = ((CW > atbs_pkg::IDX_W) ? CW : atbs_pkg::IDX_W) + 1;
  localparam int MINW = atbs_pkg::MIN_W;
  localparam int MW   = atbs_pkg::MIN_W + atbs_pkg::PTYPE_W;
  localparam int CNW  = atbs_pkg::CNT_W;
  localparam int OW   = atbs_pkg::OUT_W;

  logic [atbs_pkg::PAT_W-1:0]   pattern [atbs_pkg::NUM_CFG];
  logic [atbs_pkg::OP_W-1:0]    op;
  logic [MINW-1:0]              minute;
  logic [atbs_pkg::PTYPE_W-1:0] ptype;
  logic [atbs_pkg::IDX_W-1:0]   idx;

  logic [MW-1:0]                mem [MAX_ALARMS];
  logic [MW-1:0]                rd_data;
  logic [AW-1:0]                rd_idx;
  logic                         rd_vld;
  logic [CW-1:0]                ptr;
  logic [CW-1:0]                total;
  logic [MAX_ALARMS-1:0]        fired;
  logic [MAX_ALARMS-1:0]        fired_down;
  logic [MAX_ALARMS-1:0]        fired_shift;

  logic                         busy;
  logic                         level;
  logic                         act;
  logic                         acc;
  logic [BPW-1:0]               bitpos;
  logic [atbs_pkg::PTYPE_W-1:0] ltype;
  logic                         out_valid;
  logic [OW-1:0]                out_data;

  logic                         issue;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [MW-1:0]                mem_wd;
  logic [atbs_pkg::PAT_W-1:0]   pat_sel;
  logic [atbs_pkg::PAT_W-1:0]   pat_shift;

  assign issue = cmd.run && (ptr < total);

  assign mem_we = cmd.add_commit || (cmd.run && cmd.shift && rd_vld);
  assign mem_wa = cmd.add_commit ? total[AW-1:0] : rd_idx - 1'b1;
  assign mem_wd = cmd.add_commit ? {ptype, minute} : rd_data;

  assign fired_down = fired >> 1;

  always_comb begin
    for (int i = 0; i < MAX_ALARMS; i++) begin
      fired_shift[i] = (i >= int'(idx)) ? fired_down[i] : fired[i];
    end
  end

  assign pat_sel   = (int'(ltype) < NUM_PATTERNS) ? pattern[ltype] : '0;
  assign pat_shift = pat_sel >> bitpos;

  assign stat.op       = op;
  assign stat.full     = (total >= CW'(MAX_ALARMS));
  assign stat.idx_bad  = (XW'(idx) >= XW'(total));
  assign stat.busy     = busy;
  assign stat.hit      = rd_vld && (rd_data[MINW-1:0] == minute) &&
                         ((op == atbs_pkg::OP_ADD) || !fired[rd_idx]);
  assign stat.scan_end = (ptr >= total) && !rd_vld;
  assign stat.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < atbs_pkg::NUM_CFG; i++) begin
        pattern[i] <= '0;
      end
      total     <= '0;
      fired     <= '0;
      busy      <= 1'b0;
      bitpos    <= '0;
      ltype     <= '0;
      level     <= 1'b0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      ptr       <= '0;
      acc       <= 1'b1;
      act       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        pattern[cfg_index] <= cfg_data;
      end
      if (cmd.load) begin
        acc <= 1'b1;
        act <= 1'b0;
      end
      if (cmd.reject) begin
        acc <= 1'b0;
      end
      if (cmd.set_active) begin
        act <= 1'b1;
      end
      if (cmd.scan_start) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr    <= CW'(idx) + 1'b1;
        rd_vld <= 1'b0;
        fired  <= fired_shift;
      end else if (cmd.run) begin
        rd_vld <= issue;
        if (issue) begin
          ptr <= ptr + 1'b1;
        end
      end
      if (cmd.fire) begin
        fired[rd_idx] <= 1'b1;
        ltype         <= rd_data[MW-1:MINW];
        busy          <= 1'b1;
        act           <= 1'b1;
      end
      if (cmd.add_commit) begin
        fired[total[AW-1:0]] <= 1'b0;
        total                <= total + 1'b1;
      end
      if (cmd.dec) begin
        total <= total - 1'b1;
      end
      if (cmd.clear_fired) begin
        fired <= '0;
      end
      if (cmd.tick && busy) begin
        if (int'(bitpos) < PATTERN_BITS) begin
          level  <= pat_shift[0];
          bitpos <= bitpos + 1'b1;
        end else begin
          level  <= 1'b0;
          busy   <= 1'b0;
          bitpos <= '0;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= s_tdata[2:0];
      minute <= s_tdata[13:3];
      ptype  <= s_tdata[15:14];
      idx    <= s_tdata[21:16];
    end
    if (issue) begin
      rd_idx <= ptr[AW-1:0];
    end
    rd_data <= mem[ptr[AW-1:0]];
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.out_load) begin
      out_data <= OW'({busy, level, act, CNW'(total), acc});
    end
  end

endmodule

/* src/atbs_ctrl.sv */
module atbs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  atbs_pkg::atbs_stat_t  stat,
  output atbs_pkg::atbs_cmd_t   cmd
);

  typedef enum logic [2:0] {
    IDLE,
    DISPATCH,
    SCAN,
    SHIFT,
    DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = DISPATCH;
        end
      end
      DISPATCH: begin
        state_next = DONE;
        unique case (stat.op)
          atbs_pkg::OP_ADD: begin
            if (stat.full) begin
              cmd.reject = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = SCAN;
            end
          end
          atbs_pkg::OP_REMOVE: begin
            if (stat.idx_bad) begin
              cmd.reject = 1'b1;
            end else begin
              cmd.shift_start = 1'b1;
              state_next      = SHIFT;
            end
          end
          atbs_pkg::OP_CHECK: begin
            if (stat.busy) begin
              cmd.set_active = 1'b1;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = SCAN;
            end
          end
          atbs_pkg::OP_NEW_DAY: cmd.clear_fired = 1'b1;
          atbs_pkg::OP_TICK:    cmd.tick = 1'b1;
          default: ;
        endcase
      end
      SCAN: begin
        if (stat.hit) begin
          if (stat.op == atbs_pkg::OP_ADD) begin
            cmd.reject = 1'b1;
          end else begin
            cmd.fire = 1'b1;
          end
          state_next = DONE;
        end else if (stat.scan_end) begin
          if (stat.op == atbs_pkg::OP_ADD) begin
            cmd.add_commit = 1'b1;
          end
          state_next = DONE;
        end else begin
          cmd.run = 1'b1;
        end
      end
      SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.scan_end) begin
          cmd.dec    = 1'b1;
          state_next = DONE;
        end else begin
          cmd.run = 1'b1;
        end
      end
      DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* src/alarm_table_bell_sequencer.sv */
// One word is processed at a time; for new day, tick, unused opcodes, a check while
// ringing, an add to a full table and a rejected remove, the result word is loaded in
// DONE, right after DISPATCH, once the output is free. Add and check scan the table one
// entry per cycle, and a match ends the scan early. Remove shifts the later entries down.
// The next word is accepted in the cycle after the result is registered.
// Reset clears the patterns, the count, the fired marks and the bell; table contents stay.
module alarm_table_bell_sequencer #(
  parameter int MAX_ALARMS   = 64,
  parameter int NUM_PATTERNS = 4,
  parameter int PATTERN_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [atbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [atbs_pkg::PAT_W-1:0]     cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // opcode, minute_of_day, pattern_type, entry_index
  input  logic [atbs_pkg::IN_W-1:0]      s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accepted, entry_count, alarm_active, bell_drive, ringing
  output logic [atbs_pkg::OUT_W-1:0]     m_tdata
);

  atbs_pkg::atbs_cmd_t  cmd;
  atbs_pkg::atbs_stat_t stat;

  assign cfg_ready = 1'b1;

  atbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  atbs_datapath #(
    .MAX_ALARMS   (MAX_ALARMS),
    .NUM_PATTERNS (NUM_PATTERNS),
    .PATTERN_BITS (PATTERN_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* src/atbs_checker.sv */
`include "assert_macros.svh"

module atbs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [atbs_pkg::OUT_W-1:0] m_tdata
);

  `ATBS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
  `ATBS_ASSERT_NEXT(a_one_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready, "second word taken while one is in work")
  `ATBS_ASSERT_NOW(a_drive_needs_ring, clk, rst, m_tvalid && !m_tdata[10], !m_tdata[9], "bell driven while not ringing")
  `ATBS_ASSERT_NOW(a_active_rings, clk, rst, m_tvalid && m_tdata[8], m_tdata[10], "alarm active without ringing")

endmodule

bind alarm_table_bell_sequencer atbs_checker u_atbs_checker (.*);

/* dv/tb_alarm_table_bell_sequencer.sv */
`timescale 1ns / 100ps

module tb_alarm_table_bell_sequencer;

  localparam logic [atbs_pkg::OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [atbs_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int TABLE_DEPTH = 64;
  localparam int PLAY_BITS = 32;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 500;
  localparam int PHASE_WORDS = 200;
  localparam int DIR_ROWS = 20;

  typedef logic [atbs_pkg::OP_W-1:0]    op_t;
  typedef logic [atbs_pkg::MIN_W-1:0]   minute_t;
  typedef logic [atbs_pkg::PTYPE_W-1:0] ptype_t;
  typedef logic [atbs_pkg::IDX_W-1:0]   idx_t;

  typedef enum logic [atbs_pkg::CFG_IDX_W-1:0] {
    REG_PATTERN_ZERO,
    REG_PATTERN_ONE,
    REG_PATTERN_TWO,
    REG_PATTERN_THREE
  } pattern_reg_t;

  typedef struct packed {
    logic                       acc;
    logic [atbs_pkg::CNT_W-1:0] count;
    logic                       active;
    logic                       bell;
    logic                       ringing;
  } bell_result_t;

  typedef struct packed {
    logic [atbs_pkg::OP_W-1:0]    op;
    logic [atbs_pkg::MIN_W-1:0]   minute;
    logic [atbs_pkg::PTYPE_W-1:0] ptype;
    logic [atbs_pkg::IDX_W-1:0]   idx;
    logic                         typed;
    bell_result_t                 want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [atbs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [atbs_pkg::PAT_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [atbs_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [atbs_pkg::OUT_W-1:0] m_tdata;

  logic [atbs_pkg::MIN_W-1:0] tab_minute [TABLE_DEPTH];
  logic [atbs_pkg::PTYPE_W-1:0] tab_type [TABLE_DEPTH];
  logic tab_fired [TABLE_DEPTH];
  int tab_total;
  logic bell_on;
  logic bell_out;
  int play_pos;
  logic [atbs_pkg::PTYPE_W-1:0] play_type;
  logic [atbs_pkg::PAT_W-1:0] bell_pattern [atbs_pkg::NUM_CFG];

  bell_result_t pending_results [$];
  int err_count = 0;
  int burst_left = 0;
  int result_index = 0;

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{atbs_pkg::OP_TICK,    11'd0,    2'd0, 6'd0,  1'b1, '{1'b1, 7'd0, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_CHECK,   11'd0,    2'd0, 6'd0,  1'b1, '{1'b1, 7'd0, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_REMOVE,  11'd0,    2'd0, 6'd0,  1'b1, '{1'b0, 7'd0, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_ADD,     11'd0,    2'd0, 6'd0,  1'b1, '{1'b1, 7'd1, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_ADD,     11'd0,    2'd1, 6'd0,  1'b1, '{1'b0, 7'd1, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_ADD,     11'd1439, 2'd1, 6'd0,  1'b1, '{1'b1, 7'd2, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_ADD,     11'd2047, 2'd3, 6'd63, 1'b1, '{1'b1, 7'd3, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_ADD,     11'd720,  2'd2, 6'd0,  1'b1, '{1'b1, 7'd4, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_REMOVE,  11'd0,    2'd0, 6'd63, 1'b1, '{1'b0, 7'd4, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_REMOVE,  11'd0,    2'd0, 6'd4,  1'b1, '{1'b0, 7'd4, 1'b0, 1'b0, 1'b0}},
    '{atbs_pkg::OP_CHECK,   11'd1439, 2'd0, 6'd0,  1'b1, '{1'b1, 7'd4, 1'b1, 1'b0, 1'b1}},
    '{atbs_pkg::OP_CHECK,   11'd0,    2'd0, 6'd0,  1'b1, '{1'b1, 7'd4, 1'b1, 1'b0, 1'b1}},
    '{atbs_pkg::OP_TICK,    11'd0,    2'd0, 6'd0,  1'b1, '{1'b1, 7'd4, 1'b0, 1'b1, 1'b1}},
    '{OP_SPARE_LO,          11'd2047, 2'd3, 6'd63, 1'b0, '0},
    '{OP_SPARE_HI,          11'd2047, 2'd3, 6'd63, 1'b0, '0},
    '{atbs_pkg::OP_NEW_DAY, 11'd0,    2'd0, 6'd0,  1'b0, '0},
    '{atbs_pkg::OP_REMOVE,  11'd0,    2'd0, 6'd0,  1'b0, '0},
    '{atbs_pkg::OP_REMOVE,  11'd0,    2'd0, 6'd2,  1'b0, '0},
    '{atbs_pkg::OP_ADD,     11'd1,    2'd0, 6'd0,  1'b0, '0},
    '{atbs_pkg::OP_CHECK,   11'd2047, 2'd0, 6'd0,  1'b0, '0}
  };

  alarm_table_bell_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bell_result_t ring_table_step(logic [atbs_pkg::OP_W-1:0] op,
                                                   logic [atbs_pkg::MIN_W-1:0] minute,
                                                   logic [atbs_pkg::PTYPE_W-1:0] ptype,
                                                   logic [atbs_pkg::IDX_W-1:0] idx);
    bell_result_t r;
    bit present;
    r.acc = 1'b1;
    r.active = 1'b0;
    present = 1'b0;
    case (op)
      atbs_pkg::OP_ADD: begin
        for (int i = 0; i < tab_total; i++) begin
          if (tab_minute[i] == minute) present = 1'b1;
        end
        if (tab_total >= TABLE_DEPTH || present) begin
          r.acc = 1'b0;
        end else begin
          tab_minute[tab_total] = minute;
          tab_type[tab_total] = ptype;
          tab_fired[tab_total] = 1'b0;
          tab_total++;
        end
      end
      atbs_pkg::OP_REMOVE: begin
        if (int'(idx) >= tab_total) begin
          r.acc = 1'b0;
        end else begin
          for (int i = int'(idx); i + 1 < tab_total; i++) begin
            tab_minute[i] = tab_minute[i + 1];
            tab_type[i] = tab_type[i + 1];
            tab_fired[i] = tab_fired[i + 1];
          end
          tab_total--;
        end
      end
      atbs_pkg::OP_CHECK: begin
        if (bell_on) begin
          r.active = 1'b1;
        end else begin
          for (int i = 0; i < tab_total; i++) begin
            if (!r.active && !tab_fired[i] && tab_minute[i] == minute) begin
              tab_fired[i] = 1'b1;
              play_type = tab_type[i];
              bell_on = 1'b1;
              r.active = 1'b1;
            end
          end
        end
      end
      atbs_pkg::OP_NEW_DAY: begin
        for (int i = 0; i < TABLE_DEPTH; i++) tab_fired[i] = 1'b0;
      end
      atbs_pkg::OP_TICK: begin
        if (bell_on) begin
          if (play_pos < PLAY_BITS) begin
            bell_out = bell_pattern[play_type][play_pos];
            play_pos++;
          end else begin
            bell_out = 1'b0;
            bell_on = 1'b0;
            play_pos = 0;
          end
        end
      end
      default: ;
    endcase
    r.count = tab_total[atbs_pkg::CNT_W-1:0];
    r.bell = bell_out;
    r.ringing = bell_on;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    if (err_count <= 50)
      $display("ERROR result %0d %s: got %0d, expected %0d", result_index, what, got, want);
  endtask

  task automatic write_reg(pattern_reg_t which, logic [atbs_pkg::PAT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bell_pattern[which] = value;
    @(posedge clk);
  endtask

  task automatic write_patterns(logic [atbs_pkg::PAT_W-1:0] p0, logic [atbs_pkg::PAT_W-1:0] p1,
                                logic [atbs_pkg::PAT_W-1:0] p2, logic [atbs_pkg::PAT_W-1:0] p3);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    write_reg(REG_PATTERN_ZERO, p0);
    write_reg(REG_PATTERN_ONE, p1);
    write_reg(REG_PATTERN_TWO, p2);
    write_reg(REG_PATTERN_THREE, p3);
  endtask

  task automatic send_word(logic [atbs_pkg::OP_W-1:0] op, logic [atbs_pkg::MIN_W-1:0] minute,
                           logic [atbs_pkg::PTYPE_W-1:0] ptype, logic [atbs_pkg::IDX_W-1:0] idx,
                           bit typed, bell_result_t want);
    int gap;
    bell_result_t pred;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tdata <= {2'b00, idx, ptype, minute, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pred = ring_table_step(op, minute, ptype, idx);
    pending_results.push_back(typed ? want : pred);
  endtask

  // Result checker: each output word is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    bell_result_t got;
    bell_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.acc = m_tdata[0];
      got.count = m_tdata[7:1];
      got.active = m_tdata[8];
      got.bell = m_tdata[9];
      got.ringing = m_tdata[10];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", int'(got), 0);
      end else begin
        want = pending_results.pop_front();
        if (got.acc !== want.acc)
          report_mismatch("accepted", int'(got.acc), int'(want.acc));
        if (got.count !== want.count)
          report_mismatch("entry_count", int'(got.count), int'(want.count));
        if (got.active !== want.active)
          report_mismatch("alarm_active", int'(got.active), int'(want.active));
        if (got.bell !== want.bell)
          report_mismatch("bell_drive", int'(got.bell), int'(want.bell));
        if (got.ringing !== want.ringing)
          report_mismatch("ringing", int'(got.ringing), int'(want.ringing));
      end
      result_index++;
    end
  end

  // Output backpressure: shifting stall patterns plus two long hold-offs that fill the block.
  always @(posedge clk) begin : out_stall
    int cyc;
    int hold_left;
    int rx_seen;
    int rx_mode;
    if (m_tvalid && m_tready) rx_seen++;
    cyc++;
    if (cyc % 64 == 0) rx_mode = $urandom_range(0, 2);
    if (hold_left == 0 && (rx_seen == 150 || rx_seen == 650)) begin
      hold_left = HOLD_CYCLES;
      rx_seen++;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 7);
        default: m_tready <= (cyc % 5 != 0);
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    int stall_cycles;
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_alarm_table_bell_sequencer NOT OK");
      $finish;
    end
  end

  initial begin
    int counted;
    int add_pct;
    int rem_pct;
    int r;
    logic [atbs_pkg::OP_W-1:0] op;
    logic [atbs_pkg::MIN_W-1:0] minute;
    logic [atbs_pkg::IDX_W-1:0] idx;
    tab_total = 0;
    bell_on = 1'b0;
    bell_out = 1'b0;
    play_pos = 0;
    play_type = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) tab_fired[i] = 1'b0;
    for (int i = 0; i < atbs_pkg::NUM_CFG; i++) bell_pattern[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_patterns(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0001, 32'h5555_AAAA);
    for (int n = 0; n < DIR_ROWS; n++)
      send_word(dir_tab[n].op, dir_tab[n].minute, dir_tab[n].ptype, dir_tab[n].idx,
                dir_tab[n].typed, dir_tab[n].want);

    for (int ph = 0; ph < 5; ph++) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      case (ph)
        0: write_patterns(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
        1: write_patterns($urandom, $urandom, $urandom, $urandom);
        2: write_patterns(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0000);
        3: write_patterns(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        default: write_patterns($urandom, $urandom, 32'hFFFF_FFFF, $urandom);
      endcase
      case (ph)
        1, 3: begin add_pct = 70; rem_pct = 5; end
        2: begin add_pct = 15; rem_pct = 30; end
        default: begin add_pct = 25; rem_pct = 12; end
      endcase
      counted = 0;
      while (counted < PHASE_WORDS) begin
        r = $urandom_range(0, 99);
        minute = minute_t'($urandom_range(0, 2047));
        idx = idx_t'($urandom_range(0, 63));
        if (r < add_pct) begin
          op = atbs_pkg::OP_ADD;
          r = $urandom_range(0, 7);
          if (r == 0 && tab_total > 0) minute = tab_minute[$urandom_range(0, tab_total - 1)];
          else if (r != 1) minute = minute_t'($urandom_range(0, 1439));
        end else if (r < add_pct + rem_pct) begin
          op = atbs_pkg::OP_REMOVE;
          if ($urandom_range(0, 3) != 0)
            idx = idx_t'($urandom_range(0, (tab_total < TABLE_DEPTH) ? tab_total
                                                                     : TABLE_DEPTH - 1));
        end else if (r < add_pct + rem_pct + 15) begin
          op = atbs_pkg::OP_CHECK;
          if ($urandom_range(0, 3) != 0 && tab_total > 0)
            minute = tab_minute[$urandom_range(0, tab_total - 1)];
        end else if (r < add_pct + rem_pct + 19) begin
          op = atbs_pkg::OP_NEW_DAY;
        end else if (r < add_pct + rem_pct + 23) begin
          op = op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        end else begin
          op = atbs_pkg::OP_TICK;
        end
        if (op < OP_SPARE_LO) counted++;
        send_word(op, minute, ptype_t'($urandom_range(0, 3)), idx, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_alarm_table_bell_sequencer OK");
    end else begin
      $display("tb_alarm_table_bell_sequencer NOT OK");
    end
    $finish;
  end

endmodule

/* alarm_table_bell_sequencer.f */
+incdir+src
src/atbs_pkg.sv
src/atbs_datapath.sv
src/atbs_ctrl.sv
src/alarm_table_bell_sequencer.sv
src/atbs_checker.sv
dv/tb_alarm_table_bell_sequencer.sv
